>>> rtl/core/lrupr_pkg.sv
// Package for the LRU page replacement block.
// Holds the fixed field widths, the configuration reset value and the structs
// passed between the controller and the frame cells. No dependencies.
package lrupr_pkg;

  localparam int FI_W      = 4;   // width of the frame_index result field
  localparam int FAULT_W   = 32;  // width of the fault counter
  localparam int CFG_W     = 5;   // width of the frames_in_use register
  localparam int CFG_RESET = 16;  // frames_in_use after reset

  // Control part of the search token that walks down the cell chain.
  typedef struct packed {
    logic vld;  // token carries an item
    logic hit;  // a resident copy of the page has been found upstream
  } scan_flags_t;

  // Update command broadcast to every cell when an item completes.
  typedef struct packed {
    logic en;       // apply the update in this cycle
    logic age_all;  // age every other valid frame (fill of an empty frame)
    logic load;     // write the new page into the chosen frame
  } upd_ctl_t;

endpackage

>>> rtl/core/lrupr_in_if.sv
// Input channel of the LRU page replacement block: one page reference per item.
// Depends on nothing; used by lrupr_ctrl and lru_page_replacement_top.
interface lrupr_in_if #(
  parameter int PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

>>> rtl/core/lrupr_out_if.sv
// Result channel of the LRU page replacement block: one result per item.
// Depends on lrupr_pkg for the fixed field widths.
interface lrupr_out_if #(
  parameter int PAGE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [lrupr_pkg::FI_W-1:0]    frame_index;
  logic                         evicted_valid;
  logic [PAGE_BITS-1:0]         evicted_page;
  logic [lrupr_pkg::FAULT_W-1:0] fault_count;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_count, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_count, output ready);
endinterface

>>> rtl/core/lrupr_cell.sv
// One page frame of the LRU block: holds page, valid bit and recency rank,
// folds itself into the passing search token and applies broadcast updates.
// Depends on lrupr_pkg.
module lrupr_cell #(
  parameter int PAGE_BITS = 16,
  parameter int IDX_W     = 4,
  parameter int SZ_W      = 5,
  parameter int IDX       = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [SZ_W-1:0]        size,
  input  lrupr_pkg::scan_flags_t flags_i,
  input  logic [PAGE_BITS-1:0]   page_i,
  input  logic [IDX_W-1:0]       hit_idx_i,
  input  logic [IDX_W-1:0]       hit_rank_i,
  input  logic [IDX_W-1:0]       old_rank_i,
  input  logic [IDX_W-1:0]       old_idx_i,
  input  logic [PAGE_BITS-1:0]   old_page_i,
  output lrupr_pkg::scan_flags_t flags_o,
  output logic [PAGE_BITS-1:0]   page_o,
  output logic [IDX_W-1:0]       hit_idx_o,
  output logic [IDX_W-1:0]       hit_rank_o,
  output logic [IDX_W-1:0]       old_rank_o,
  output logic [IDX_W-1:0]       old_idx_o,
  output logic [PAGE_BITS-1:0]   old_page_o,
  input  lrupr_pkg::upd_ctl_t    upd,
  input  logic [IDX_W-1:0]       upd_idx,
  input  logic [IDX_W-1:0]       upd_limit,
  input  logic [PAGE_BITS-1:0]   upd_page
);

  localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(IDX);
  localparam logic [SZ_W-1:0]  MY_SIZE = SZ_W'(IDX);

  logic [PAGE_BITS-1:0] page_r, page_nxt;
  logic                 valid_r, valid_nxt;
  logic [IDX_W-1:0]     rank_r, rank_nxt;

  lrupr_pkg::scan_flags_t flags_r, flags_nxt;
  logic [PAGE_BITS-1:0]   tpage_r;
  logic [IDX_W-1:0]       hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]       hit_rank_r, hit_rank_nxt;
  logic [IDX_W-1:0]       old_rank_r, old_rank_nxt;
  logic [IDX_W-1:0]       old_idx_r, old_idx_nxt;
  logic [PAGE_BITS-1:0]   old_page_r, old_page_nxt;

  logic in_range;
  logic match;
  logic older;

  assign in_range = MY_SIZE < size;
  assign match    = in_range && valid_r && (page_r == page_i) && !flags_i.hit;
  // Ranks are distinct, so >= only matters for the first valid frame seen.
  assign older    = in_range && valid_r && (rank_r >= old_rank_i);

  always_comb begin
    flags_nxt     = flags_i;
    hit_idx_nxt   = hit_idx_i;
    hit_rank_nxt  = hit_rank_i;
    old_rank_nxt  = old_rank_i;
    old_idx_nxt   = old_idx_i;
    old_page_nxt  = old_page_i;
    if (match) begin
      flags_nxt.hit = 1'b1;
      hit_idx_nxt   = MY_IDX;
      hit_rank_nxt  = rank_r;
    end
    if (older) begin
      old_rank_nxt = rank_r;
      old_idx_nxt  = MY_IDX;
      old_page_nxt = page_r;
    end
  end

  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    if (upd.en) begin
      if (upd_idx == MY_IDX) begin
        rank_nxt = '0;
        if (upd.load) begin
          page_nxt  = upd_page;
          valid_nxt = 1'b1;
        end
      end else if (valid_r && (upd.age_all || (rank_r < upd_limit))) begin
        rank_nxt = IDX_W'(rank_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
      flags_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r     <= page_nxt;
    tpage_r    <= page_i;
    hit_idx_r  <= hit_idx_nxt;
    hit_rank_r <= hit_rank_nxt;
    old_rank_r <= old_rank_nxt;
    old_idx_r  <= old_idx_nxt;
    old_page_r <= old_page_nxt;
  end

  assign flags_o    = flags_r;
  assign page_o     = tpage_r;
  assign hit_idx_o  = hit_idx_r;
  assign hit_rank_o = hit_rank_r;
  assign old_rank_o = old_rank_r;
  assign old_idx_o  = old_idx_r;
  assign old_page_o = old_page_r;

endmodule

>>> rtl/core/lrupr_ctrl.sv
// Controller of the LRU block: channel handshakes, frames_in_use register,
// fill count, fault counter, final decision and the update broadcast.
// Depends on lrupr_pkg, lrupr_in_if and lrupr_out_if.
module lrupr_ctrl #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16,
  parameter int IDX_W     = 4,
  parameter int SZ_W      = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata,
  lrupr_in_if.sink                    in_ch,
  lrupr_out_if.source                 out_ch,
  output logic [SZ_W-1:0]             size,
  output lrupr_pkg::scan_flags_t      inj_flags,
  output logic [PAGE_BITS-1:0]        inj_page,
  input  lrupr_pkg::scan_flags_t      last_flags,
  input  logic [PAGE_BITS-1:0]        last_page,
  input  logic [IDX_W-1:0]            last_hit_idx,
  input  logic [IDX_W-1:0]            last_hit_rank,
  input  logic [IDX_W-1:0]            last_old_rank,
  input  logic [IDX_W-1:0]            last_old_idx,
  input  logic [PAGE_BITS-1:0]        last_old_page,
  output lrupr_pkg::upd_ctl_t         upd,
  output logic [IDX_W-1:0]            upd_idx,
  output logic [IDX_W-1:0]            upd_limit,
  output logic [PAGE_BITS-1:0]        upd_page
);

  localparam int CFGW = lrupr_pkg::CFG_W;
  localparam int FIW  = lrupr_pkg::FI_W;
  localparam int FLTW = lrupr_pkg::FAULT_W;
  localparam int CW   = (SZ_W > CFGW) ? SZ_W : CFGW;
  localparam logic [CW-1:0]   FRAMES_C  = CW'(FRAMES);
  localparam logic [CFGW-1:0] CFG_RST_C = CFGW'(lrupr_pkg::CFG_RESET);

  logic [CFGW-1:0] cfg_r;
  logic [SZ_W-1:0] occ_r, occ_nxt;
  logic [FLTW-1:0] faults_r, faults_nxt;
  logic            busy_r, busy_nxt;
  logic            fin_vld_r, fin_vld_nxt;
  logic            out_vld_r, out_vld_nxt;

  logic                 fin_hit_r;
  logic [PAGE_BITS-1:0] fin_page_r;
  logic [IDX_W-1:0]     fin_hit_idx_r, fin_hit_rank_r, fin_old_rank_r, fin_old_idx_r;
  logic [PAGE_BITS-1:0] fin_old_page_r;

  logic                 out_hit_r;
  logic [FIW-1:0]       out_idx_r;
  logic                 out_ev_r;
  logic [PAGE_BITS-1:0] out_evpage_r;
  logic [FLTW-1:0]      out_fault_r;

  logic [CW-1:0]    cfg_ext;
  logic             accept;
  logic             complete;
  logic             is_fill;
  logic             is_evict;
  logic [IDX_W-1:0] frame;

  // Effective size: zero acts as one, anything above FRAMES acts as FRAMES.
  assign cfg_ext = CW'(cfg_r);
  always_comb begin
    if (cfg_ext == '0) begin
      size = SZ_W'(1);
    end else if (cfg_ext > FRAMES_C) begin
      size = SZ_W'(FRAMES);
    end else begin
      size = SZ_W'(cfg_ext);
    end
  end

  assign in_ch.ready = rst_n && !busy_r;
  assign accept      = in_ch.valid && rst_n && !busy_r;
  assign inj_flags   = '{vld: accept, hit: 1'b0};
  assign inj_page    = in_ch.page_number;

  assign complete = fin_vld_r && (!out_vld_r || out_ch.ready);
  assign is_fill  = !fin_hit_r && (occ_r < size);
  assign is_evict = !fin_hit_r && !is_fill;

  always_comb begin
    if (fin_hit_r) begin
      frame = fin_hit_idx_r;
    end else if (is_fill) begin
      frame = IDX_W'(occ_r);
    end else begin
      frame = fin_old_idx_r;
    end
  end

  assign upd       = '{en: complete, age_all: is_fill, load: !fin_hit_r};
  assign upd_idx   = frame;
  assign upd_limit = fin_hit_r ? fin_hit_rank_r : fin_old_rank_r;
  assign upd_page  = fin_page_r;

  always_comb begin
    occ_nxt     = occ_r;
    faults_nxt  = faults_r;
    busy_nxt    = busy_r;
    fin_vld_nxt = fin_vld_r;
    out_vld_nxt = out_vld_r;
    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
    if (last_flags.vld) begin
      fin_vld_nxt = 1'b1;
    end
    if (complete) begin
      fin_vld_nxt = 1'b0;
      busy_nxt    = 1'b0;
      out_vld_nxt = 1'b1;
      if (is_fill) begin
        occ_nxt = SZ_W'(occ_r + 1'b1);
      end
      if (!fin_hit_r && (faults_r != '1)) begin
        faults_nxt = faults_r + 1'b1;
      end
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= CFG_RST_C;
      occ_r     <= '0;
      faults_r  <= '0;
      busy_r    <= 1'b0;
      fin_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      occ_r     <= occ_nxt;
      faults_r  <= faults_nxt;
      busy_r    <= busy_nxt;
      fin_vld_r <= fin_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (last_flags.vld) begin
      fin_hit_r      <= last_flags.hit;
      fin_page_r     <= last_page;
      fin_hit_idx_r  <= last_hit_idx;
      fin_hit_rank_r <= last_hit_rank;
      fin_old_rank_r <= last_old_rank;
      fin_old_idx_r  <= last_old_idx;
      fin_old_page_r <= last_old_page;
    end
    if (complete) begin
      out_hit_r    <= fin_hit_r;
      out_idx_r    <= FIW'(frame);
      out_ev_r     <= is_evict;
      out_evpage_r <= is_evict ? fin_old_page_r : '0;
      out_fault_r  <= faults_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.frame_index   = out_idx_r;
  assign out_ch.evicted_valid = out_ev_r;
  assign out_ch.evicted_page  = out_evpage_r;
  assign out_ch.fault_count   = out_fault_r;

  // A finished item waits in the end stage only while the block is busy with it.
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fin_vld_r |-> busy_r)
    else $error("end stage holds an item while the block is idle");

  // The fill count never passes the number of frames.
  a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= SZ_W'(FRAMES))
    else $error("fill count beyond FRAMES");

  // A completed item always lands in the result register.
  a_cmp_out: assert property (@(posedge clk) disable iff (!rst_n)
    complete |=> out_vld_r)
    else $error("completed item not presented");

  // No item is taken while another is being searched.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy_r && !in_ch.ready))
    else $error("second item accepted during a search");

endmodule

>>> rtl/core/lru_page_replacement_top.sv
// Top level of the LRU page replacement block: the controller and a chain
// of FRAMES frame cells. Depends on lrupr_pkg, lrupr_in_if, lrupr_out_if,
// lrupr_cell and lrupr_ctrl.
//
//   Channel  Direction  Handshake              Content
//   in_ch    in         valid/ready            page_number
//   out_ch   out        valid/ready            hit, frame_index, evicted_*, fault_count
//   cfg_     in         cfg_we, no back-press  frames_in_use (5 bits)
//
// An item's search token walks the cell chain one cell per cycle and lands in
// the end stage; there the controller decides and broadcasts the update to all
// frames once the result register is free or is being taken. No new item is
// taken before the previous one completes; the input is ready again in the
// same cycle that the result appears.
// Synchronous active-low reset empties every frame, clears the fault count and
// sets frames_in_use to 16. While the result register is full, the next item
// is still taken; its finished search then waits in the end stage.
module lru_page_replacement_top #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata,
  lrupr_in_if.sink                    in_ch,
  lrupr_out_if.source                 out_ch
);

  localparam int IDX_W = $clog2(FRAMES);
  localparam int SZ_W  = $clog2(FRAMES + 1);

  logic [SZ_W-1:0] size;

  lrupr_pkg::scan_flags_t st_flags    [FRAMES+1];
  logic [PAGE_BITS-1:0]   st_page     [FRAMES+1];
  logic [IDX_W-1:0]       st_hit_idx  [FRAMES+1];
  logic [IDX_W-1:0]       st_hit_rank [FRAMES+1];
  logic [IDX_W-1:0]       st_old_rank [FRAMES+1];
  logic [IDX_W-1:0]       st_old_idx  [FRAMES+1];
  logic [PAGE_BITS-1:0]   st_old_page [FRAMES+1];

  lrupr_pkg::upd_ctl_t  upd;
  logic [IDX_W-1:0]     upd_idx;
  logic [IDX_W-1:0]     upd_limit;
  logic [PAGE_BITS-1:0] upd_page;

  // A fresh token has found nothing yet.
  assign st_hit_idx[0]  = '0;
  assign st_hit_rank[0] = '0;
  assign st_old_rank[0] = '0;
  assign st_old_idx[0]  = '0;
  assign st_old_page[0] = '0;

  lrupr_ctrl #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IDX_W     (IDX_W),
    .SZ_W      (SZ_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .size          (size),
    .inj_flags     (st_flags[0]),
    .inj_page      (st_page[0]),
    .last_flags    (st_flags[FRAMES]),
    .last_page     (st_page[FRAMES]),
    .last_hit_idx  (st_hit_idx[FRAMES]),
    .last_hit_rank (st_hit_rank[FRAMES]),
    .last_old_rank (st_old_rank[FRAMES]),
    .last_old_idx  (st_old_idx[FRAMES]),
    .last_old_page (st_old_page[FRAMES]),
    .upd           (upd),
    .upd_idx       (upd_idx),
    .upd_limit     (upd_limit),
    .upd_page      (upd_page)
  );

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lrupr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .IDX_W     (IDX_W),
      .SZ_W      (SZ_W),
      .IDX       (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .size       (size),
      .flags_i    (st_flags[g]),
      .page_i     (st_page[g]),
      .hit_idx_i  (st_hit_idx[g]),
      .hit_rank_i (st_hit_rank[g]),
      .old_rank_i (st_old_rank[g]),
      .old_idx_i  (st_old_idx[g]),
      .old_page_i (st_old_page[g]),
      .flags_o    (st_flags[g+1]),
      .page_o     (st_page[g+1]),
      .hit_idx_o  (st_hit_idx[g+1]),
      .hit_rank_o (st_hit_rank[g+1]),
      .old_rank_o (st_old_rank[g+1]),
      .old_idx_o  (st_old_idx[g+1]),
      .old_page_o (st_old_page[g+1]),
      .upd        (upd),
      .upd_idx    (upd_idx),
      .upd_limit  (upd_limit),
      .upd_page   (upd_page)
    );
  end

endmodule

>>> tb/lru_page_replacement_top_tb.sv
// Self-checking testbench for lru_page_replacement_top: page references in, hit/miss results out.
// Depends on lrupr_pkg, lrupr_in_if, lrupr_out_if and the block itself; a class tracks the
// frame contents and recency ranks to predict every result, random idling on both channels.
`timescale 1ns / 1ps

module lru_page_replacement_top_tb;

  localparam int FRAMES     = 16;
  localparam int PAGE_BITS  = 16;
  localparam int LATENCY    = FRAMES + 2;
  localparam int RAND_ITEMS = 650;
  localparam int CYCLE_CAP  = 400000;

  typedef struct packed {
    logic                          hit;
    logic [lrupr_pkg::FI_W-1:0]    frame;
    logic                          ev_valid;
    logic [PAGE_BITS-1:0]          ev_page;
    logic [lrupr_pkg::FAULT_W-1:0] faults;
  } lru_result_t;

  // Mirror of the frame table; works out the result of each accepted reference.
  class lru_tracker;
    logic [PAGE_BITS-1:0]          page_of  [FRAMES];
    bit                            held     [FRAMES];
    int                            age_rank [FRAMES];
    int                            filled;
    logic [lrupr_pkg::FAULT_W-1:0] fault_tally;
    int                            frames_cfg;
    lru_result_t                   awaiting [$];
    int                            errors;
    int                            refs_seen;
    int                            hits_seen;
    int                            evictions_seen;

    function new();
      for (int i = 0; i < FRAMES; i++) begin
        page_of[i]  = '0;
        held[i]     = 1'b0;
        age_rank[i] = 0;
      end
      filled         = 0;
      fault_tally    = '0;
      frames_cfg     = lrupr_pkg::CFG_RESET;
      errors         = 0;
      refs_seen      = 0;
      hits_seen      = 0;
      evictions_seen = 0;
    endfunction

    function void set_frames(int value);
      frames_cfg = value & 31;
    endfunction

    // Frame f becomes the most recent; valid frames younger than limit age by one.
    function void make_recent(int f, int limit);
      for (int i = 0; i < FRAMES; i++) begin
        if (held[i] && i != f && age_rank[i] < limit) age_rank[i]++;
      end
      age_rank[f] = 0;
    endfunction

    function void note_reference(logic [PAGE_BITS-1:0] pg);
      lru_result_t r;
      int          size;
      int          f;
      int          oldest;
      bit          found;
      size  = frames_cfg;
      f     = 0;
      found = 1'b0;
      r     = '0;
      if (size < 1) size = 1;
      if (size > FRAMES) size = FRAMES;
      for (int i = 0; i < size; i++) begin
        if (!found && held[i] && page_of[i] == pg) begin
          found = 1'b1;
          f     = i;
        end
      end
      if (found) begin
        make_recent(f, age_rank[f]);
        hits_seen++;
      end else if (filled < size) begin
        f           = filled;
        held[f]     = 1'b1;
        page_of[f]  = pg;
        age_rank[f] = 0;
        make_recent(f, FRAMES + 1);
        filled++;
        if (fault_tally != '1) fault_tally++;
      end else begin
        oldest = 0;
        for (int i = 0; i < size; i++) begin
          if (held[i] && age_rank[i] >= oldest) begin
            oldest = age_rank[i];
            f      = i;
          end
        end
        r.ev_valid = 1'b1;
        r.ev_page  = page_of[f];
        page_of[f] = pg;
        make_recent(f, oldest);
        if (fault_tally != '1) fault_tally++;
        evictions_seen++;
      end
      r.hit    = found;
      r.frame  = f[lrupr_pkg::FI_W-1:0];
      r.faults = fault_tally;
      awaiting.push_back(r);
      refs_seen++;
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(lru_result_t act);
      lru_result_t exp_r;
      if (awaiting.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, got %h", $time, act);
        errors++;
      end else begin
        exp_r = awaiting.pop_front();
        compare_field("hit", 32'(exp_r.hit), 32'(act.hit));
        compare_field("frame_index", 32'(exp_r.frame), 32'(act.frame));
        compare_field("evicted_valid", 32'(exp_r.ev_valid), 32'(act.ev_valid));
        compare_field("evicted_page", 32'(exp_r.ev_page), 32'(act.ev_page));
        compare_field("fault_count", exp_r.faults, act.faults);
      end
    endfunction

    function int outstanding();
      return awaiting.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        cfg_we;
  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata;

  lrupr_in_if  #(.PAGE_BITS(PAGE_BITS)) in_ch ();
  lrupr_out_if #(.PAGE_BITS(PAGE_BITS)) out_ch ();

  lru_page_replacement_top #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(PAGE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  lru_tracker tracker;
  bit         calm_tail = 1'b0;
  int         stall_left = 0;
  int         cycle_count = 0;
  int         settings_used = 0;
  int         sender_idle_pct = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("lru_page_replacement_top verification failed");
      $finish;
    end
  end

  // Handshake monitor: pre-edge values are read, so ordering within the step does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) tracker.note_reference(in_ch.page_number);
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_result({out_ch.hit, out_ch.frame_index, out_ch.evicted_valid,
                              out_ch.evicted_page, out_ch.fault_count});
      end
    end
  end

  // Result back-pressure in random bursts, switched off for the final stretch.
  always @(posedge clk) begin
    if (!rst_n || calm_tail) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_ch.ready) begin
      if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left   <= $urandom_range(1, 18) - 1;
      end else begin
        stall_left <= $urandom_range(0, 25);
      end
    end else begin
      out_ch.ready <= 1'b1;
      stall_left   <= $urandom_range(0, 30);
    end
  end

  task automatic send_ref(input logic [PAGE_BITS-1:0] pg);
    if (!calm_tail && sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.page_number <= pg;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_frames(input int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[lrupr_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_frames(value);
    settings_used++;
  endtask

  initial begin
    logic [PAGE_BITS-1:0] pool [$];
    int extremes [7];
    int sent;
    int phase_len;
    int eff;
    int setting;
    int phase_no;
    int wait_cycles;

    extremes = '{1, 16, 0, 31, 17, 15, 2};
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.page_number = '0;
    tracker = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A size of zero behaves as a single frame.
    write_frames(0);
    send_ref(16'h0000);
    send_ref(16'h0000);
    send_ref(16'hFFFF);
    send_ref(16'hFFFF);
    drain_results();

    // Growing the size fills the empty frames before anything is evicted.
    write_frames(3);
    send_ref(16'h1234);
    send_ref(16'h5678);
    send_ref(16'hFFFF);
    send_ref(16'h0000);
    send_ref(16'h1234);
    send_ref(16'h0000);
    drain_results();

    // Above the frame count the size is clamped; fill every frame.
    write_frames(20);
    for (int i = 3; i < FRAMES; i++) send_ref(16'hA5A5 ^ 16'(i));
    send_ref(16'h5678);
    drain_results();

    // Shrunk below the occupied frames: a page parked above the size misses and is duplicated.
    write_frames(2);
    send_ref(16'hA5A5 ^ 16'd7);
    send_ref(16'hA5A5 ^ 16'd7);
    send_ref(16'h5A5A);
    drain_results();

    sent     = 0;
    phase_no = 0;
    while (sent < RAND_ITEMS) begin
      setting = (phase_no < 7) ? extremes[phase_no] : $urandom_range(0, 31);
      write_frames(setting);
      eff = (setting < 1) ? 1 : (setting > FRAMES) ? FRAMES : setting;
      pool.delete();
      repeat (eff + $urandom_range(0, eff + 3)) pool.push_back(16'($urandom_range(0, 65535)));
      phase_len = $urandom_range(30, 70);
      if (RAND_ITEMS - sent <= 80) begin
        phase_len = RAND_ITEMS - sent;
        calm_tail = 1'b1;
      end
      sender_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      for (int k = 0; k < phase_len; k++) begin
        // Mostly a working set that produces hits and evictions, with some stray pages.
        if ($urandom_range(0, 9) < 8) send_ref(pool[$urandom_range(0, pool.size() - 1)]);
        else send_ref(16'($urandom_range(0, 65535)));
      end
      sent += phase_len;
      phase_no++;
      drain_results();
    end

    wait_cycles = 0;
    while (tracker.outstanding() != 0 && wait_cycles < 50 * LATENCY) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (2 * LATENCY) @(posedge clk);

    $display("Run covered %0d page references under %0d frame settings,",
             tracker.refs_seen, settings_used);
    $display("with %0d hits and %0d evictions.", tracker.hits_seen, tracker.evictions_seen);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("lru_page_replacement_top verification clean");
    end else begin
      $display("lru_page_replacement_top verification failed");
    end
    $finish;
  end

endmodule
